### hw/rtl/gcps_pkg.sv
// Package for the gated coincidence pair selector.
// Holds field widths, register indexes, reset values and the controller types.
// No dependencies.
package gcps_pkg;

   localparam int NUM_LINES  = 6;
   localparam int ENERGY_W   = 16;
   localparam int TIME_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int WEIGHT_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_PROMPT_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELAYED_MIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_ZERO    = 3'd2;

   localparam logic [LIMIT_W-1:0] PROMPT_LIMIT_RESET = 15'd30;
   localparam logic [TIME_W-1:0]  DELAYED_MIN_RESET  = 16'd30;

   typedef logic [NUM_LINES-1:0][ENERGY_W-1:0] line_set_type;

   localparam line_set_type LINE_RESET = {16'd12352, 16'd10480, 16'd8186,
                                          16'd7871, 16'd3630, 16'd3408};

   typedef struct packed {
      logic [LIMIT_W-1:0]       prompt_limit;
      logic signed [TIME_W-1:0] delayed_min;
      line_set_type             lines;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_PAIR  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   typedef struct packed {
      logic hit_take;
      logic hit_last;
      logic scan_en;
      logic pair_start;
      logic pair_en;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic pair_done;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/gcps_channels.sv
// Valid/ready channel interfaces for hits and pair results.
// Depends on gcps_pkg for field widths.
interface gcps_req_if import gcps_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [ENERGY_W-1:0]        gate_energy;
   logic [ENERGY_W-1:0]        matrix_energy;
   logic signed [TIME_W-1:0]   time_diff;
   logic                       last_hit;

   modport source (output valid, gate_energy, matrix_energy, time_diff, last_hit,
                   input ready);
   modport sink   (input valid, gate_energy, matrix_energy, time_diff, last_hit,
                   output ready);
endinterface

interface gcps_rsp_if import gcps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ENERGY_W-1:0]   energy_x;
   logic [ENERGY_W-1:0]   energy_y;
   logic [WEIGHT_W-1:0]   weight;
   logic                  last_result;
   logic                  overflow;

   modport source (output valid, energy_x, energy_y, weight, last_result, overflow,
                   input ready);
   modport sink   (input valid, energy_x, energy_y, weight, last_result, overflow,
                   output ready);
endinterface

### hw/rtl/gated_coincidence_pair_selector_top.sv
// Top level of the gated coincidence pair selector.
// Depends on gcps_pkg, gcps_channels, gcps_csr, gcps_ctrl and gcps_dp.
//
// The block collects the hits of one event, one hit per cycle, into small
// hit memories of MAX_HITS entries; hits past that depth are dropped and the
// event is marked as overflowed. The hit flagged last_hit closes the event.
// The block then scans the N stored hits, one hit memory read per cycle,
// to mark prompt hits and delayed hits that fall inside one of the six gate
// windows, and walks all N * N ordered index pairs at one pair per cycle
// while the result path is not stalled. Each pair of two distinct prompt
// hits with a nonzero count of gated delayed hits (the pair itself
// excluded) leaves as one transfer on the result channel. One result is
// held back so that the final one can carry last_result; an event with no
// qualifying pair gives a single zero-weight marker. Stalls on the result
// channel stretch the pair walk.
// New hits are refused from the last hit until the final result is loaded.
// Configuration registers are written through a plain write port with
// indexes 0 (prompt_limit), 1 (delayed_min) and 2 to 7 (gate lines); the
// gate windows are open intervals of width 2 * GATE_HALF around each line.
module gated_coincidence_pair_selector_top import gcps_pkg::*; #(
   parameter int MAX_HITS  = 8,
   parameter int GATE_HALF = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   gcps_req_if.sink              req_chan,
   gcps_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   // configuration registers
   gcps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: accept hits, then scan, walk pairs and flush
   gcps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_hit),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // storage, classification, pair counters and result registers
   gcps_dp #(
      .MAX_HITS  (MAX_HITS),
      .GATE_HALF (GATE_HALF)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg),
      .in_gate      (req_chan.gate_energy),
      .in_matrix    (req_chan.matrix_energy),
      .in_time      (req_chan.time_diff),
      .rsp_ready    (rsp_chan.ready),
      .status       (status),
      .rsp_valid    (rsp_chan.valid),
      .rsp_energy_x (rsp_chan.energy_x),
      .rsp_energy_y (rsp_chan.energy_y),
      .rsp_weight   (rsp_chan.weight),
      .rsp_last     (rsp_chan.last_result),
      .rsp_overflow (rsp_chan.overflow)
   );

endmodule

### hw/rtl/gcps_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module gcps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/gcps_csr.sv
// Configuration registers: prompt window, delayed threshold and six gate lines.
// Depends on gcps_pkg.
module gcps_csr import gcps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type                 cfg_ff;
   logic [CSR_IDX_W-1:0]    line_sel;

   assign line_sel = csr_index - REG_LINE_ZERO;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prompt_limit <= PROMPT_LIMIT_RESET;
         cfg_ff.delayed_min  <= DELAYED_MIN_RESET;
         cfg_ff.lines        <= LINE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PROMPT_LIMIT: cfg_ff.prompt_limit <= csr_wdata[LIMIT_W-1:0];
            REG_DELAYED_MIN:  cfg_ff.delayed_min  <= csr_wdata;
            default:          cfg_ff.lines[line_sel] <= csr_wdata;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/gcps_ctrl.sv
// Event sequencer: hit collection, hit scan, pair walk and end-of-event flush.
// Depends on gcps_pkg.
module gcps_ctrl import gcps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      take;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_ready && req_valid;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.hit_take   = take;
      cmd.hit_last   = req_last;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.scan_done) begin
               cmd.pair_start = 1'b1;
               state_in       = ST_PAIR;
            end
         end
         ST_PAIR: begin
            cmd.pair_en = 1'b1;
            if (status.pair_done) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/gcps_dp.sv
// Datapath: hit memories, per-hit flags, pair counters, pending and output registers.
// Depends on gcps_pkg and gcps_ram.
module gcps_dp import gcps_pkg::*; #(
   parameter int MAX_HITS  = 8,
   parameter int GATE_HALF = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  cfg_type                  cfg,
   input  logic [ENERGY_W-1:0]      in_gate,
   input  logic [ENERGY_W-1:0]      in_matrix,
   input  logic signed [TIME_W-1:0] in_time,
   input  logic                     rsp_ready,
   output status_type               status,
   output logic                     rsp_valid,
   output logic [ENERGY_W-1:0]      rsp_energy_x,
   output logic [ENERGY_W-1:0]      rsp_energy_y,
   output logic [WEIGHT_W-1:0]      rsp_weight,
   output logic                     rsp_last,
   output logic                     rsp_overflow
);

   localparam int IW = $clog2(MAX_HITS);
   localparam int CW = $clog2(MAX_HITS + 1);
   localparam int EW = $clog2(65536 + GATE_HALF);
   localparam int HW = ENERGY_W + TIME_W;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_HITS);
   localparam logic [EW-1:0] HALF      = EW'(GATE_HALF);

   // hit collection
   logic [CW-1:0]   hit_count_ff;
   logic            overflow_ff;
   logic            room;
   logic            store_we;

   // scan of stored hits
   logic [CW-1:0]   scan_k_ff;
   logic            scan_v_ff;
   logic [IW-1:0]   scan_idx_ff;
   logic            scan_issue;
   logic [HW-1:0]   hit_rdata;
   logic [MAX_HITS-1:0] prompt_ff;
   logic [MAX_HITS-1:0] gd_ff;
   logic [CW-1:0]   gcount_ff;
   logic [ENERGY_W-1:0]      sc_gate;
   logic signed [TIME_W-1:0] sc_time;
   logic signed [LIMIT_W+1:0] sc_time_x;
   logic signed [LIMIT_W+1:0] sc_lim_x;
   logic            sc_prompt;
   logic            sc_line_hit;
   logic            sc_gd;

   // pair walk
   logic [IW-1:0]   pi_ff, pj_ff;
   logic            run_ff;
   logic [CW-1:0]   weight_full;
   logic            pair_ok;
   logic            pj_end, pi_end;
   logic            advance, step;
   logic            s1_valid_ff;
   logic [WEIGHT_W-1:0] s1_weight_ff;
   logic [ENERGY_W-1:0] mx_rdata, my_rdata;

   // pending and output registers
   logic            pend_valid_ff;
   logic [ENERGY_W-1:0] pend_x_ff, pend_y_ff;
   logic [WEIGHT_W-1:0] pend_w_ff;
   logic            out_valid_ff;
   logic [ENERGY_W-1:0] out_x_ff, out_y_ff;
   logic [WEIGHT_W-1:0] out_w_ff;
   logic            out_last_ff, out_ovf_ff;
   logic            out_free;
   logic            push_pend;
   logic            flush_load;

   assign room     = (hit_count_ff != MAX_COUNT);
   assign store_we = cmd.hit_take && room;

   gcps_ram #(.WIDTH(HW), .DEPTH(MAX_HITS)) u_hit_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (hit_count_ff[IW-1:0]),
      .wdata ({in_gate, in_time}),
      .re    (scan_issue),
      .raddr (scan_k_ff[IW-1:0]),
      .rdata (hit_rdata)
   );

   gcps_ram #(.WIDTH(ENERGY_W), .DEPTH(MAX_HITS)) u_mx_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (hit_count_ff[IW-1:0]),
      .wdata (in_matrix),
      .re    (step && run_ff),
      .raddr (pi_ff),
      .rdata (mx_rdata)
   );

   gcps_ram #(.WIDTH(ENERGY_W), .DEPTH(MAX_HITS)) u_my_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (hit_count_ff[IW-1:0]),
      .wdata (in_matrix),
      .re    (step && run_ff),
      .raddr (pj_ff),
      .rdata (my_rdata)
   );

   // classify one stored hit
   assign scan_issue = cmd.scan_en && (scan_k_ff != hit_count_ff);
   assign sc_gate    = hit_rdata[HW-1:TIME_W];
   assign sc_time    = $signed(hit_rdata[TIME_W-1:0]);
   assign sc_time_x  = (LIMIT_W+2)'(sc_time);
   assign sc_lim_x   = $signed({2'b00, cfg.prompt_limit});
   assign sc_prompt  = (sc_time_x <= sc_lim_x) && (sc_time_x >= -sc_lim_x);

   always_comb begin
      logic [EW-1:0] e_x;
      logic [EW-1:0] c_x;
      e_x         = EW'(sc_gate);
      sc_line_hit = 1'b0;
      for (int n = 0; n < NUM_LINES; n++) begin
         c_x = EW'(cfg.lines[n]);
         if ((e_x + HALF > c_x) && (e_x < c_x + HALF)) sc_line_hit = 1'b1;
      end
   end

   assign sc_gd = sc_line_hit && (sc_time >= cfg.delayed_min);

   // pair evaluation
   assign weight_full = gcount_ff - CW'(gd_ff[pi_ff]) - CW'(gd_ff[pj_ff]);
   assign pair_ok     = prompt_ff[pi_ff] && prompt_ff[pj_ff] && (pi_ff != pj_ff) &&
                        (weight_full != '0);
   assign pj_end      = (CW'(pj_ff) == hit_count_ff - CW'(1));
   assign pi_end      = (CW'(pi_ff) == hit_count_ff - CW'(1));

   assign out_free   = !out_valid_ff || rsp_ready;
   assign advance    = !(s1_valid_ff && pend_valid_ff) || out_free;
   assign step       = cmd.pair_en && advance;
   assign push_pend  = step && s1_valid_ff && pend_valid_ff;
   assign flush_load = cmd.flush && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_count_ff  <= '0;
         overflow_ff   <= 1'b0;
         scan_k_ff     <= '0;
         scan_v_ff     <= 1'b0;
         prompt_ff     <= '0;
         gd_ff         <= '0;
         gcount_ff     <= '0;
         run_ff        <= 1'b0;
         pi_ff         <= '0;
         pj_ff         <= '0;
         s1_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.hit_take) begin
            if (room) hit_count_ff <= hit_count_ff + CW'(1);
            else      overflow_ff  <= 1'b1;
            if (cmd.hit_last) begin
               scan_k_ff <= '0;
               prompt_ff <= '0;
               gd_ff     <= '0;
               gcount_ff <= '0;
            end
         end

         scan_v_ff <= scan_issue;
         if (scan_issue) scan_k_ff <= scan_k_ff + CW'(1);
         if (scan_v_ff) begin
            prompt_ff[scan_idx_ff] <= sc_prompt;
            gd_ff[scan_idx_ff]     <= sc_gd;
            gcount_ff              <= gcount_ff + CW'(sc_gd);
         end

         if (cmd.pair_start) begin
            run_ff <= (hit_count_ff != '0);
            pi_ff  <= '0;
            pj_ff  <= '0;
         end else if (step) begin
            s1_valid_ff <= run_ff && pair_ok;
            if (run_ff) begin
               if (pj_end) begin
                  pj_ff <= '0;
                  pi_ff <= pi_ff + IW'(1);
                  if (pi_end) run_ff <= 1'b0;
               end else begin
                  pj_ff <= pj_ff + IW'(1);
               end
            end
            if (s1_valid_ff) pend_valid_ff <= 1'b1;
         end

         if (push_pend || flush_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end

         if (flush_load) begin
            pend_valid_ff <= 1'b0;
            hit_count_ff  <= '0;
            overflow_ff   <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (scan_issue) scan_idx_ff <= scan_k_ff[IW-1:0];
      if (step && run_ff) s1_weight_ff <= WEIGHT_W'(weight_full);
      if (step && s1_valid_ff) begin
         pend_x_ff <= mx_rdata;
         pend_y_ff <= my_rdata;
         pend_w_ff <= s1_weight_ff;
      end
      if (push_pend) begin
         out_x_ff    <= pend_x_ff;
         out_y_ff    <= pend_y_ff;
         out_w_ff    <= pend_w_ff;
         out_last_ff <= 1'b0;
         out_ovf_ff  <= overflow_ff;
      end else if (flush_load) begin
         out_x_ff    <= pend_valid_ff ? pend_x_ff : '0;
         out_y_ff    <= pend_valid_ff ? pend_y_ff : '0;
         out_w_ff    <= pend_valid_ff ? pend_w_ff : '0;
         out_last_ff <= 1'b1;
         out_ovf_ff  <= overflow_ff;
      end
   end

   assign status.scan_done = (scan_k_ff == hit_count_ff) && !scan_v_ff;
   assign status.pair_done = !run_ff && !s1_valid_ff;
   assign status.out_free  = out_free;

   assign rsp_valid    = out_valid_ff;
   assign rsp_energy_x = out_x_ff;
   assign rsp_energy_y = out_y_ff;
   assign rsp_weight   = out_w_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_overflow = out_ovf_ff;

endmodule
